>>> hdl/sliding_window_median_top_macros.svh
// ----------------------------------------------------------------------------
// sliding window median: assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, switched off while reset is asserted
`define SWM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define SWM_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWM_ASSERT(label, clk, rst_n, prop, msg)
`define SWM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> hdl/swm_pkg.sv
// ----------------------------------------------------------------------------
// sliding window median: package
// shared constants and the control structs between top level and core
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// window length register
	localparam int CFG_W     = 7;
	localparam int CFG_RESET = 3;

	// compare flags of the shared unit
	typedef struct packed {
		logic eq;
		logic gt;
	} swm_cmp_t;

	// top level to core
	typedef struct packed {
		logic start;
		logic clear;
		logic take;
	} swm_cmd_t;

	// core to top level
	typedef struct packed {
		logic busy;
		logic res_valid;
	} swm_stat_t;

endpackage

>>> hdl/swm_alu.sv
// ----------------------------------------------------------------------------
// sliding window median: shared compare and add unit
// equality and signed greater-than of two samples, and their widened sum
// ----------------------------------------------------------------------------
module swm_alu import swm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic signed [SAMPLE_BITS-1:0] a,
	input  logic signed [SAMPLE_BITS-1:0] b,
	output swm_cmp_t                      cmp,
	output logic signed [SAMPLE_BITS:0]   sum
);

	always_comb begin
		cmp.eq = (a == b);
		cmp.gt = (a > b);
		sum    = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
	end

endmodule

>>> hdl/swm_core.sv
// ----------------------------------------------------------------------------
// sliding window median: core
// arrival ring, sorted store and the sequencer that drives the shared unit
// ----------------------------------------------------------------------------
`include "sliding_window_median_top_macros.svh"

module swm_core import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int LEN_W      = $clog2(WINDOW_MAX + 1),
	localparam int ADDR_W     = $clog2(WINDOW_MAX)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swm_cmd_t                      cmd,
	input  logic [LEN_W-1:0]              len,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output swm_stat_t                     stat,
	output logic signed [SAMPLE_BITS:0]   res
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RING_RD,
		ST_RM,
		ST_INS0,
		ST_INS,
		ST_INS_END,
		ST_MED0,
		ST_MED1,
		ST_MED2,
		ST_RESULT
	} state_t;

	state_t                        state_q;
	logic [ADDR_W-1:0]             rp_q;
	logic [LEN_W-1:0]              fill_q;
	logic [ADDR_W-1:0]             pa_q;
	logic [ADDR_W-1:0]             ip_q;
	logic                          found_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic signed [SAMPLE_BITS-1:0] acc_q;
	logic signed [SAMPLE_BITS:0]   res_q;

	// memories
	logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] srt_mem  [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] ring_rd_q;
	logic signed [SAMPLE_BITS-1:0] srt_rd_q;

	logic                          ring_we;
	logic [ADDR_W-1:0]             ring_a;
	logic                          srt_we;
	logic [ADDR_W-1:0]             srt_wa;
	logic signed [SAMPLE_BITS-1:0] srt_wd;
	logic [ADDR_W-1:0]             srt_ra;

	logic [ADDR_W-1:0]             rp_eff;
	logic [LEN_W-1:0]              rp_inc;
	logic [ADDR_W-1:0]             mid;
	logic                          rm_last;

	logic signed [SAMPLE_BITS-1:0] alu_b;
	swm_cmp_t                      cmp;
	logic signed [SAMPLE_BITS:0]   sum;

	swm_alu #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_alu (
		.a  (srt_rd_q),
		.b  (alu_b),
		.cmp(cmp),
		.sum(sum)
	);

	always_comb begin
		rp_eff  = (LEN_W'(rp_q) >= len) ? '0 : rp_q;
		rp_inc  = LEN_W'(rp_eff) + LEN_W'(1);
		mid     = ADDR_W'((len - LEN_W'(1)) >> 1);
		rm_last = (LEN_W'(pa_q) == (fill_q - LEN_W'(1)));

		ring_we = (state_q == ST_IDLE) && cmd.start;
		ring_a  = rp_eff;

		case (state_q)
			ST_RM:   alu_b = old_q;
			ST_MED1: alu_b = srt_rd_q;
			ST_MED2: alu_b = acc_q;
			default: alu_b = x_q;
		endcase

		srt_we = 1'b0;
		srt_wa = ip_q;
		srt_wd = x_q;
		srt_ra = '0;
		case (state_q)
			ST_RM: begin
				srt_we = found_q;
				srt_wa = pa_q - ADDR_W'(1);
				srt_wd = srt_rd_q;
				srt_ra = pa_q + ADDR_W'(1);
			end
			ST_INS0: begin
				srt_we = (fill_q == '0);
				srt_wa = '0;
				srt_ra = ADDR_W'(fill_q - LEN_W'(1));
			end
			ST_INS: begin
				srt_we = 1'b1;
				srt_wd = cmp.gt ? srt_rd_q : x_q;
				srt_ra = ip_q - ADDR_W'(2);
			end
			ST_INS_END: begin
				srt_we = 1'b1;
			end
			ST_MED0: srt_ra = mid;
			ST_MED1: srt_ra = mid + ADDR_W'(1);
			default: srt_ra = '0;
		endcase
	end

	// arrival ring, read before write at the same slot
	always_ff @(posedge clk) begin
		ring_rd_q <= ring_mem[ring_a];
		if (ring_we) begin
			ring_mem[ring_a] <= sample;
		end
	end

	// sorted store
	always_ff @(posedge clk) begin
		srt_rd_q <= srt_mem[srt_ra];
		if (srt_we) begin
			srt_mem[srt_wa] <= srt_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rp_q    <= '0;
			fill_q  <= '0;
			found_q <= 1'b0;
			pa_q    <= '0;
			ip_q    <= '0;
			x_q     <= '0;
			old_q   <= '0;
			acc_q   <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.clear) begin
						fill_q <= '0;
						rp_q   <= '0;
					end else if (cmd.start) begin
						x_q  <= sample;
						rp_q <= (rp_inc >= len) ? '0 : ADDR_W'(rp_inc);
						if (fill_q >= len) begin
							state_q <= ST_RING_RD;
						end else begin
							state_q <= ST_INS0;
						end
					end
				end
				ST_RING_RD: begin
					old_q   <= ring_rd_q;
					pa_q    <= '0;
					found_q <= 1'b0;
					state_q <= ST_RM;
				end
				ST_RM: begin
					if (!found_q && cmp.eq) begin
						found_q <= 1'b1;
					end
					pa_q <= pa_q + ADDR_W'(1);
					if (rm_last) begin
						fill_q  <= fill_q - LEN_W'(1);
						state_q <= ST_INS0;
					end
				end
				ST_INS0: begin
					if (fill_q == '0) begin
						fill_q  <= fill_q + LEN_W'(1);
						state_q <= ST_MED0;
					end else begin
						ip_q    <= ADDR_W'(fill_q);
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					if (cmp.gt) begin
						ip_q <= ip_q - ADDR_W'(1);
						if (ip_q == ADDR_W'(1)) begin
							state_q <= ST_INS_END;
						end
					end else begin
						fill_q  <= fill_q + LEN_W'(1);
						state_q <= ST_MED0;
					end
				end
				ST_INS_END: begin
					fill_q  <= fill_q + LEN_W'(1);
					state_q <= ST_MED0;
				end
				ST_MED0: begin
					if (fill_q < len) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MED1;
					end
				end
				ST_MED1: begin
					if (len[0]) begin
						res_q   <= sum;
						state_q <= ST_RESULT;
					end else begin
						acc_q   <= srt_rd_q;
						state_q <= ST_MED2;
					end
				end
				ST_MED2: begin
					res_q   <= sum;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (cmd.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		stat.busy      = (state_q != ST_IDLE);
		stat.res_valid = (state_q == ST_RESULT);
	end

	assign res = res_q;

	`SWM_ASSERT(a_fill_bound, clk, arst_n, (state_q == ST_IDLE) |-> (fill_q <= len), "fill count above window length")
	`SWM_ASSERT(a_ptr_bound, clk, arst_n, (state_q == ST_IDLE) |-> (LEN_W'(rp_q) < len), "ring pointer outside window")
	`SWM_ASSERT(a_full_result, clk, arst_n, (state_q == ST_RESULT) |-> (fill_q == len), "result from a window not full")
	`SWM_ASSERT(a_match_found, clk, arst_n, (state_q == ST_RM && rm_last) |-> (found_q || cmp.eq), "retired sample missing from sorted store")
	`SWM_ASSERT_ALWAYS(a_idle_no_write, clk, (state_q == ST_IDLE) |-> !srt_we, "sorted store written while idle")

endmodule

>>> hdl/sliding_window_median_top.sv
// results: a result beat follows an accepted sample only once the window is full;
//   while the window fills, accepted samples give no result beat
// samples: a new one waits until the core is idle and any result taken; the removal
//   sweep and insertion walk go one entry per cycle on the single sorted-store write port
// reset: arst_n asynchronous active low; window empties, window length returns to 3,
//   the sample stores hold no valid contents until written
// ----------------------------------------------------------------------------
// sliding window median: top level
// running median over the last window_len signed samples, given as twice the
// median; one shared compare and add unit walks a sorted store per sample
// ----------------------------------------------------------------------------
module sliding_window_median_top import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beats
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// result beats
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS:0]   median_x2,
	// window length register
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_W-1:0]              window_len
);

	localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
	localparam int LEN_RST = (CFG_RESET > WINDOW_MAX) ? WINDOW_MAX : CFG_RESET;

	logic [LEN_W-1:0]            len_q;
	logic [LEN_W-1:0]            cfg_len;
	logic                        out_valid_q;
	logic signed [SAMPLE_BITS:0] median_x2_q;

	swm_cmd_t                    cmd;
	swm_stat_t                   stat;
	logic signed [SAMPLE_BITS:0] core_res;
	logic                        cfg_wr;
	logic                        out_load;

	// a pending register write wins over a sample in the same cycle
	assign in_stall  = stat.busy | cfg_valid;
	assign cfg_ready = !stat.busy;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// output register is free when empty or being drained this cycle
	assign out_load  = stat.res_valid & (!out_valid_q | !out_stall);

	always_comb begin
		cmd.start = in_valid & !in_stall;
		cmd.clear = cfg_wr;
		cmd.take  = out_load;
	end

	// zero acts as one, anything above the store depth is clamped to it
	always_comb begin
		if (window_len == '0) begin
			cfg_len = LEN_W'(1);
		end else if (32'(window_len) > 32'(WINDOW_MAX)) begin
			cfg_len = LEN_W'(WINDOW_MAX);
		end else begin
			cfg_len = LEN_W'(window_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(LEN_RST);
		end else if (cfg_wr) begin
			len_q <= cfg_len;
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			median_x2_q <= core_res;
		end
	end

	assign out_valid = out_valid_q;
	assign median_x2 = median_x2_q;

	swm_core #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.len   (len_q),
		.sample(sample),
		.stat  (stat),
		.res   (core_res)
	);

endmodule
